### rtl/core/bfa_pkg.sv
// Shared types, widths and codes for the bitmap frame allocator.
// Depends on nothing; every other file of the block imports it.
package bfa_pkg;

    // Field widths fixed by the item formats.
    localparam int OP_W    = 2;
    localparam int FIRST_W = 16;
    localparam int CNT_W   = 17;
    localparam int TOT_W   = 17;
    localparam int FRAME_W = 16;
    localparam int ST_W    = 2;

    // Internal frame arithmetic: wide enough for a start frame plus a count.
    localparam int FR_W    = 18;
    // Bit positions inside a bitmap word, including the word width itself.
    localparam int POS_W   = 7;

    // Defaults of the top-level parameters.
    localparam int DEF_MAX_FRAMES = 65536;
    localparam int DEF_WORD_BITS  = 64;

    // Reset value of the total_frames register.
    localparam logic [TOT_W-1:0] TOTAL_RESET = TOT_W'(65536);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;

    // Status codes.
    localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
    localparam logic [ST_W-1:0] ST_OOM     = 2'd1;
    localparam logic [ST_W-1:0] ST_IGNORED = 2'd2;

    // What the word unit reports about one scan step.
    typedef struct packed {
        logic             hit_free; // a free bit exists at or above the pointer
        logic             at_ptr;   // that free bit is the pointer bit itself
        logic [POS_W-1:0] free_pos; // first free bit at or above the pointer
        logic [POS_W-1:0] run_len;  // free bits from free_pos up to the next used bit
    } t_scan_res;

endpackage

### rtl/core/bfa_in_if.sv
// Request channel of the bitmap frame allocator: valid/ready and one operation.
// Depends on bfa_pkg for the field widths.
interface bfa_in_if import bfa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [FIRST_W-1:0] first_frame;
    logic [CNT_W-1:0]   frame_count;

    modport source (output valid, operation, first_frame, frame_count, input ready);
    modport sink   (input valid, operation, first_frame, frame_count, output ready);
endinterface

### rtl/core/bfa_out_if.sv
// Response channel of the bitmap frame allocator: valid/ready, frame and status.
// Depends on bfa_pkg for the field widths.
interface bfa_out_if import bfa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] frame;
    logic [ST_W-1:0]    status;

    modport source (output valid, frame, status, input ready);
    modport sink   (input valid, frame, status, output ready);
endinterface

### rtl/core/bfa_bitmap_mem.sv
// Single-port bitmap store with a registered read port.
// Depends on bfa_pkg for the default parameter values.
module bfa_bitmap_mem import bfa_pkg::*; #(
    parameter int NUM_WORDS = DEF_MAX_FRAMES / DEF_WORD_BITS,
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic                 i_re,
    input  logic [ADDR_W-1:0]    i_addr,
    input  logic [WORD_BITS-1:0] i_wdata,
    output logic [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/bfa_word_unit.sv
// Shared word unit: free-stretch search within one bitmap word and range mask generation.
// Depends on bfa_pkg for the scan result struct and position width.
module bfa_word_unit import bfa_pkg::*; #(
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic [WORD_BITS-1:0] i_word,  // used bits of the word
    input  logic [POS_W-1:0]     i_ptr,   // lowest bit of interest
    input  logic [POS_W-1:0]     i_hi,    // bits at and above this lie outside the range
    output t_scan_res            o_scan,
    output logic [WORD_BITS-1:0] o_mask   // bits from i_ptr up to i_hi
);

    // Bits at or above a position.
    function automatic logic [WORD_BITS-1:0] ge_mask(input logic [POS_W-1:0] p);
        logic [WORD_BITS-1:0] m;
        for (int i = 0; i < WORD_BITS; i++) begin
            m[i] = (POS_W'(i) >= p);
        end
        return m;
    endfunction

    // Bits below a position.
    function automatic logic [WORD_BITS-1:0] lt_mask(input logic [POS_W-1:0] p);
        logic [WORD_BITS-1:0] m;
        for (int i = 0; i < WORD_BITS; i++) begin
            m[i] = (POS_W'(i) < p);
        end
        return m;
    endfunction

    // Index of the lowest set bit, or the word width when none is set.
    function automatic logic [POS_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [POS_W-1:0] pos;
        pos = POS_W'(WORD_BITS);
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = POS_W'(i);
            end
        end
        return pos;
    endfunction

    logic [WORD_BITS-1:0] ptr_mask;
    logic [WORD_BITS-1:0] used_eff;
    logic [WORD_BITS-1:0] free_vec;
    logic [POS_W-1:0]     free_pos;
    logic [POS_W-1:0]     stop_pos;

    // Frames outside the range count as used, so a stretch never crosses the limit.
    assign ptr_mask = ge_mask(i_ptr);
    assign used_eff = i_word | ~lt_mask(i_hi);
    assign free_vec = ~used_eff & ptr_mask;
    assign free_pos = lowest_set(free_vec);
    assign stop_pos = lowest_set(used_eff & ge_mask(free_pos));

    always_comb begin
        o_scan.hit_free = |free_vec;
        o_scan.at_ptr   = (free_pos == i_ptr);
        o_scan.free_pos = free_pos;
        o_scan.run_len  = stop_pos - free_pos;
    end

    assign o_mask = ptr_mask & lt_mask(i_hi);

endmodule

### rtl/core/bitmap_frame_allocator.sv
// Bitmap frame allocator top level: request sequencer around the bitmap store and word unit.
// Depends on bfa_pkg, bfa_in_if, bfa_out_if, bfa_bitmap_mem and bfa_word_unit.
//
// The block keeps one used/free bit per page frame in a memory of MAX_FRAMES/WORD_BITS words
// and serves one request at a time. After reset a clearing pass writes one word per cycle,
// every word of the memory, before the first request is taken; writes of total_frames are
// accepted during that pass. An allocation reads the bitmap from word 0 upwards, first fit:
// each word is read in FETCH and scanned in SCAN, with one more scan step for every free
// stretch inside that word that is too short and ends below the top of the word. A free or
// reserve, and the marking of a run just allocated, is a read-modify-write of every word the
// range touches, in FETCH and then MODIFY. A request with a zero count or an unknown
// operation goes from IDLE straight to DONE. The result sits in an output register, and a
// new request is taken while it waits to be collected.
module bitmap_frame_allocator import bfa_pkg::*; #(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES,
    parameter int WORD_BITS  = DEF_WORD_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [TOT_W-1:0] i_cfg_wdata,
    bfa_in_if.sink           i_item,
    bfa_out_if.source        o_res
);

    localparam int NUM_WORDS = MAX_FRAMES / WORD_BITS;
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int WB_W      = $clog2(WORD_BITS);
    localparam int LIM_CAP   = (MAX_FRAMES > 131071) ? 131071 : MAX_FRAMES;

    // Sequencer states.
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_FETCH  = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_MODIFY = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [TOT_W-1:0]   r_total;
    logic               r_scan, n_scan;     // word loop is an allocation search
    logic               r_set, n_set;       // range writes ones (reserve) or zeros (free)
    logic [FR_W-1:0]    r_first, n_first;
    logic [FR_W-1:0]    r_end, n_end;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [FR_W-1:0]    r_widx, n_widx;
    logic [POS_W-1:0]   r_ptr, n_ptr;
    logic [CNT_W-1:0]   r_run, n_run;
    logic [FR_W-1:0]    r_start, n_start;
    logic [ADDR_W-1:0]  r_clr;
    logic [FRAME_W-1:0] r_res_frame, n_res_frame;
    logic [ST_W-1:0]    r_res_status, n_res_status;
    logic               r_ovalid;
    logic [FRAME_W-1:0] r_oframe;
    logic [ST_W-1:0]    r_ostatus;

    logic [TOT_W-1:0]     lim;
    logic [FR_W-1:0]      base;
    logic [FR_W-1:0]      diff_end;
    logic [FR_W-1:0]      diff_first;
    logic [POS_W-1:0]     hi;
    logic [POS_W-1:0]     lo;
    logic                 last_word;
    logic [WORD_BITS-1:0] rdata;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] wdata;
    t_scan_res            scan;
    logic [CNT_W-1:0]     run_eff;
    logic [CNT_W:0]       run_sum;
    logic [FR_W-1:0]      run_start;
    logic [POS_W-1:0]     stretch_end;
    logic [FR_W-1:0]      range_end;
    logic                 in_fire;
    logic                 out_free;
    logic                 mem_we;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_addr;

    // Managed limit and the position of the current word against it.
    assign lim        = (r_total > TOT_W'(LIM_CAP)) ? TOT_W'(LIM_CAP) : r_total;
    assign base       = r_widx << WB_W;
    assign diff_end   = r_end - base;
    assign diff_first = r_first - base;
    assign last_word  = (r_end <= base + FR_W'(WORD_BITS));

    always_comb begin
        if (r_end <= base) begin
            hi = '0;
        end else if (diff_end >= FR_W'(WORD_BITS)) begin
            hi = POS_W'(WORD_BITS);
        end else begin
            hi = diff_end[POS_W-1:0];
        end
        lo = (r_first > base) ? diff_first[POS_W-1:0] : '0;
    end

    // Shared word unit.
    bfa_word_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_word (
        .i_word (rdata),
        .i_ptr  (r_scan ? r_ptr : lo),
        .i_hi   (hi),
        .o_scan (scan),
        .o_mask (mask)
    );

    // Bitmap store: cleared after reset, read in FETCH, written back in MODIFY.
    assign mem_we   = (r_state == S_CLEAR) || (r_state == S_MODIFY);
    assign mem_re   = (r_state == S_FETCH);
    assign mem_addr = (r_state == S_CLEAR) ? r_clr : ADDR_W'(r_widx);
    assign wdata    = (r_state == S_CLEAR) ? '0 : (r_set ? (rdata | mask) : (rdata & ~mask));

    bfa_bitmap_mem #(
        .NUM_WORDS (NUM_WORDS),
        .WORD_BITS (WORD_BITS),
        .ADDR_W    (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    // Scan step arithmetic: extend the carried run or start a new one.
    assign run_eff     = scan.at_ptr ? r_run : '0;
    assign run_sum     = (CNT_W + 1)'(run_eff) + (CNT_W + 1)'(scan.run_len);
    assign run_start   = (scan.at_ptr && (r_run != '0)) ? r_start
                                                        : base + FR_W'(scan.free_pos);
    assign stretch_end = scan.free_pos + scan.run_len;

    // End of a free or reserve range, clipped to the managed limit.
    always_comb begin
        range_end = FR_W'(i_item.first_frame) + FR_W'(i_item.frame_count);
        if (range_end > FR_W'(lim)) begin
            range_end = FR_W'(lim);
        end
    end

    assign in_fire      = i_item.valid && i_item.ready;
    assign out_free     = !r_ovalid || o_res.ready;
    assign i_item.ready = (r_state == S_IDLE);

    // Sequencer next-state logic.
    always_comb begin
        n_state      = r_state;
        n_scan       = r_scan;
        n_set        = r_set;
        n_first      = r_first;
        n_end        = r_end;
        n_count      = r_count;
        n_widx       = r_widx;
        n_ptr        = r_ptr;
        n_run        = r_run;
        n_start      = r_start;
        n_res_frame  = r_res_frame;
        n_res_status = r_res_status;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == ADDR_W'(NUM_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_res_frame  = '0;
                    n_res_status = ST_DONE;
                    n_count      = i_item.frame_count;
                    if (i_item.frame_count == '0 ||
                        !(i_item.operation inside {OP_ALLOC, OP_FREE, OP_RESERVE})) begin
                        n_res_status = ST_IGNORED;
                        n_state      = S_DONE;
                    end else if (i_item.operation == OP_ALLOC) begin
                        n_scan  = 1'b1;
                        n_set   = 1'b1;
                        n_first = '0;
                        n_end   = FR_W'(lim);
                        n_widx  = '0;
                        n_ptr   = '0;
                        n_run   = '0;
                        n_state = S_FETCH;
                    end else begin
                        n_scan  = 1'b0;
                        n_set   = (i_item.operation == OP_RESERVE);
                        n_first = FR_W'(i_item.first_frame);
                        n_end   = range_end;
                        n_widx  = FR_W'(i_item.first_frame) >> WB_W;
                        n_state = (FR_W'(i_item.first_frame) >= range_end) ? S_DONE : S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_state = r_scan ? S_SCAN : S_MODIFY;
            end
            S_SCAN: begin
                if (scan.hit_free && (run_sum >= (CNT_W + 1)'(r_count))) begin
                    // Run found: mark it used through the range loop.
                    n_res_frame = run_start[FRAME_W-1:0];
                    n_scan      = 1'b0;
                    n_first     = run_start;
                    n_end       = run_start + FR_W'(r_count);
                    n_widx      = run_start >> WB_W;
                    n_state     = S_FETCH;
                end else if (scan.hit_free && (stretch_end != POS_W'(WORD_BITS))) begin
                    // Stretch too short and ends inside this word: look further on.
                    n_run   = run_sum[CNT_W-1:0];
                    n_start = run_start;
                    n_ptr   = stretch_end;
                end else begin
                    // Word exhausted; a stretch reaching its top carries into the next word.
                    n_run   = scan.hit_free ? run_sum[CNT_W-1:0] : '0;
                    n_start = run_start;
                    n_ptr   = '0;
                    if (last_word) begin
                        n_res_status = ST_OOM;
                        n_state      = S_DONE;
                    end else begin
                        n_widx  = r_widx + FR_W'(1);
                        n_state = S_FETCH;
                    end
                end
            end
            S_MODIFY: begin
                if (last_word) begin
                    n_state = S_DONE;
                end else begin
                    n_widx  = r_widx + FR_W'(1);
                    n_state = S_FETCH;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_total  <= TOTAL_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
            end
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_scan       <= n_scan;
        r_set        <= n_set;
        r_first      <= n_first;
        r_end        <= n_end;
        r_count      <= n_count;
        r_widx       <= n_widx;
        r_ptr        <= n_ptr;
        r_run        <= n_run;
        r_start      <= n_start;
        r_res_frame  <= n_res_frame;
        r_res_status <= n_res_status;
        if (r_state == S_DONE && out_free) begin
            r_oframe  <= r_res_frame;
            r_ostatus <= r_res_status;
        end
    end

    assign o_res.valid  = r_ovalid;
    assign o_res.frame  = r_oframe;
    assign o_res.status = r_ostatus;

endmodule

### rtl/core/bfa_checker.sv
// Port-level checks for the bitmap frame allocator, bound to the top level.
// Depends on bfa_pkg for the status codes and field widths.
module bfa_checker import bfa_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [FRAME_W-1:0] i_out_frame,
    input logic [ST_W-1:0]    i_out_status
);

    // A result waiting to be collected is not withdrawn.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before transfer");

    // Only one request is in service at a time: a transfer closes the request port.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request port still open after a transfer");

    // A failed or ignored request reports frame zero.
    a_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != ST_DONE) |-> (i_out_frame == '0))
        else $error("frame non-zero on a failed or ignored request");

    // Reset leaves no result pending and the request port closed.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_ready)
        else $error("result or request port active right after reset");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_item.valid),
    .i_in_ready   (i_item.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_frame  (o_res.frame),
    .i_out_status (o_res.status)
);

### sim/bfa_grant_checker.sv
// Grant checker for the bitmap frame allocator: keeps its own frame bitmap, predicts the grant
// of every accepted request and compares it with the grants the block hands out.
// Depends on bfa_pkg and on the bfa_in_if and bfa_out_if channel interfaces.
module bfa_grant_checker import bfa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [TOT_W-1:0] i_cfg_wdata,
    bfa_in_if                i_req,
    bfa_out_if               i_grant,
    output int               o_fail_count,
    output int               o_outstanding
);

    localparam int WB        = DEF_WORD_BITS;
    localparam int MAP_WORDS = DEF_MAX_FRAMES / DEF_WORD_BITS;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [ST_W-1:0]    status;
    } grant_t;

    logic [WB-1:0]    used_map [MAP_WORDS];
    logic [TOT_W-1:0] frames_present;
    grant_t           awaited_grants [$];
    int               n_failures = 0;

    // Frames taking part in any operation: the register value, capped at the bitmap size.
    function automatic int unsigned managed_frames();
        return (frames_present > DEF_MAX_FRAMES) ? DEF_MAX_FRAMES : frames_present;
    endfunction

    // Sets or clears the bits of a range, clipped to the managed frames, one word at a time.
    function automatic void mark_range(input int unsigned first, input int unsigned count,
                                       input logic used);
        int unsigned stop;
        int unsigned lo;
        int unsigned hi;
        logic [WB-1:0] mask;
        stop = first + count;
        if (stop > managed_frames())
            stop = managed_frames();
        if (first >= stop)
            return;
        for (int unsigned w = first / WB; w <= (stop - 1) / WB; w++) begin
            lo   = (w * WB < first) ? first - w * WB : 0;
            hi   = ((w + 1) * WB > stop) ? stop - w * WB : WB;
            mask = ({WB{1'b1}} << lo) & ({WB{1'b1}} >> (WB - hi));
            if (used)
                used_map[w] = used_map[w] | mask;
            else
                used_map[w] = used_map[w] & ~mask;
        end
    endfunction

    // First-fit search upwards from frame 0; whole full or empty words are taken in one step.
    function automatic bit find_first_fit(input int unsigned count, output int unsigned start);
        int unsigned lim;
        int unsigned f;
        int unsigned run;
        int unsigned s;
        logic [WB-1:0] word;
        bit whole;
        lim   = managed_frames();
        f     = 0;
        run   = 0;
        s     = 0;
        start = 0;
        while (f < lim) begin
            word  = used_map[f / WB];
            whole = (f % WB == 0) && (f + WB <= lim);
            if (whole && word == '1) begin
                run = 0;
                f   = f + WB;
            end else if (whole && word == '0) begin
                if (run == 0)
                    s = f;
                if (run + WB >= count) begin
                    start = s;
                    return 1'b1;
                end
                run = run + WB;
                f   = f + WB;
            end else begin
                if (word[f % WB]) begin
                    run = 0;
                end else begin
                    if (run == 0)
                        s = f;
                    run++;
                    if (run == count) begin
                        start = s;
                        return 1'b1;
                    end
                end
                f++;
            end
        end
        return 1'b0;
    endfunction

    // Applies one request to the bitmap and works out the grant it should produce.
    function automatic grant_t serve_request(input logic [OP_W-1:0] op,
                                             input logic [FIRST_W-1:0] first,
                                             input logic [CNT_W-1:0] count);
        grant_t g;
        int unsigned start;
        g.frame  = '0;
        g.status = ST_DONE;
        if (count == '0) begin
            g.status = ST_IGNORED;
        end else begin
            case (op)
                OP_ALLOC: begin
                    if (find_first_fit(count, start)) begin
                        mark_range(start, count, 1'b1);
                        g.frame = FRAME_W'(start);
                    end else begin
                        g.status = ST_OOM;
                    end
                end
                OP_FREE:    mark_range(first, count, 1'b0);
                OP_RESERVE: mark_range(first, count, 1'b1);
                default:    g.status = ST_IGNORED;
            endcase
        end
        return g;
    endfunction

    task automatic report_mismatch(input string what);
        n_failures++;
        $display("%0t: %s", $time, what);
    endtask

    // Track register writes and request transfers, and check every grant transfer in order.
    always @(posedge i_clk) begin
        grant_t want;
        if (!i_rst_n) begin
            for (int w = 0; w < MAP_WORDS; w++)
                used_map[w] = '0;
            frames_present = TOTAL_RESET;
            awaited_grants.delete();
        end else begin
            if (i_cfg_we)
                frames_present = i_cfg_wdata;
            if (i_req.valid && i_req.ready)
                awaited_grants.push_back(serve_request(i_req.operation, i_req.first_frame,
                                                       i_req.frame_count));
            if (i_grant.valid && i_grant.ready) begin
                if (awaited_grants.size() == 0) begin
                    report_mismatch($sformatf("grant with no request waiting: frame %0d status %0d",
                                              i_grant.frame, i_grant.status));
                end else begin
                    want = awaited_grants.pop_front();
                    if (i_grant.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_grant.status, want.status));
                    if (i_grant.frame !== want.frame)
                        report_mismatch($sformatf("frame %0d, expected %0d",
                                                  i_grant.frame, want.frame));
                end
            end
        end
        o_outstanding <= awaited_grants.size();
        o_fail_count  <= n_failures;
    end

endmodule

### sim/bitmap_frame_allocator_test.sv
// Top of the bitmap frame allocator testbench: clock, reset, register writes, request and
// grant traffic with random gaps, and the verdict. Depends on bfa_pkg, the channel
// interfaces, bitmap_frame_allocator and bfa_grant_checker.
module bitmap_frame_allocator_test;
    import bfa_pkg::*;

    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    localparam int MAP_WORDS = DEF_MAX_FRAMES / DEF_WORD_BITS;
    localparam int MAX_GAP   = 17;
    // Long receiver hold-off, started once after this many grant transfers.
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 3000;
    // Slowest request: a search over the whole bitmap where every word holds alternating free
    // and used frames (a read, one scan per free stretch and a closing scan for each word),
    // marking every word, and both sides at their longest gap. For MAX_REQUESTS such requests
    // and the clearing pass, taken three times over, with the long hold-off on top.
    localparam int PER_REQUEST  = (DEF_WORD_BITS / 2 + 4) * MAP_WORDS + 2 * MAX_GAP + 64;
    localparam int MAX_REQUESTS = 650;
    localparam int LIMIT_CYCLES = 3 * (MAP_WORDS + MAX_REQUESTS * PER_REQUEST) + HOLD_CYCLES;

    // Random phases: frame total for each (negative draws a small one) and request count.
    localparam int N_PHASES = 9;
    localparam int PHASE_TOTAL [N_PHASES] = '{300, 64, 1000, 1, 0, 131071, 4096, -1, 130};
    localparam int PHASE_ITEMS [N_PHASES] = '{80, 60, 100, 20, 10, 30, 100, 100, 55};

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [TOT_W-1:0] cfg_wdata;
    int               fail_count;
    int               outstanding;
    int               cycle_count = 0;
    bit               quiet_sender = 1'b0;
    bit               quiet_receiver = 1'b0;

    bfa_in_if  req_ch ();
    bfa_out_if grant_ch ();

    bitmap_frame_allocator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (req_ch),
        .o_res       (grant_ch)
    );

    bfa_grant_checker grant_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_req         (req_ch),
        .i_grant       (grant_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles with %0d grants outstanding",
                     cycle_count, outstanding);
            $display("bitmap_frame_allocator_test NOT OK");
            $finish;
        end
    end

    // Offers one request after a random gap and holds it until its transfer.
    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [FIRST_W-1:0] first,
                                input logic [CNT_W-1:0] count);
        int gap;
        gap = quiet_sender ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.operation   = op;
        req_ch.first_frame = first;
        req_ch.frame_count = count;
        req_ch.valid       = 1'b1;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Writes the frame total once every grant so far has been collected.
    task automatic set_frames_present(input logic [TOT_W-1:0] value);
        req_ch.valid = 1'b0;
        do @(posedge clk); while (outstanding != 0);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Random request: mostly small runs near the bottom of the managed frames, with
    // frees outnumbering reserves so that the bitmap keeps opening up again.
    task automatic draw_request(input int unsigned lim, output logic [OP_W-1:0] op,
                                output logic [FIRST_W-1:0] first,
                                output logic [CNT_W-1:0] count);
        int unsigned span;
        int unsigned pick;
        int unsigned size_pick;
        span      = (lim == 0) ? 64 : ((lim > 4096) ? 4096 : lim);
        pick      = $urandom_range(0, 99);
        size_pick = $urandom_range(0, 99);
        if (size_pick < 60)
            count = CNT_W'($urandom_range(1, 8));
        else if (size_pick < 85)
            count = CNT_W'($urandom_range(1, 64));
        else if (size_pick < 96)
            count = CNT_W'($urandom_range(1, span));
        else
            count = CNT_W'($urandom_range(1, 131071));
        if (pick % 10 == 0)
            first = FIRST_W'($urandom);
        else
            first = FIRST_W'($urandom_range(0, span - 1));
        if (pick < 4)
            op = OP_UNKNOWN;
        else if (pick < 46)
            op = OP_ALLOC;
        else if (pick < 80)
            op = OP_FREE;
        else
            op = OP_RESERVE;
        // A few allocation requests with a zero count.
        if (pick >= 4 && pick < 8)
            count = '0;
    endtask

    // Grant side: random stalls per grant, one long hold-off counted here.
    initial begin : grant_receiver
        int stall;
        int served;
        served = 0;
        grant_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            stall = quiet_receiver ? 0 : $urandom_range(0, MAX_GAP);
            if (served == HOLD_AT)
                stall = HOLD_CYCLES;
            if (stall > 0) begin
                grant_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            grant_ch.ready = 1'b1;
            do @(posedge clk); while (!grant_ch.valid);
            served++;
        end
    end

    // Request side and verdict.
    initial begin : request_sender
        int unsigned lim;
        logic [OP_W-1:0]    op;
        logic [FIRST_W-1:0] first;
        logic [CNT_W-1:0]   count;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        req_ch.valid       = 1'b0;
        req_ch.operation   = OP_ALLOC;
        req_ch.first_frame = '0;
        req_ch.frame_count = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Full bitmap: zero counts, unknown operation, runs across words, clipping.
        set_frames_present(TOTAL_RESET);
        send_request(OP_ALLOC,   16'd0,     17'd0);
        send_request(OP_FREE,    16'hFFFF,  17'd0);
        send_request(OP_RESERVE, 16'd7,     17'd0);
        send_request(OP_UNKNOWN, 16'hFFFF,  17'h1FFFF);
        send_request(OP_ALLOC,   16'hA5A5,  17'd1);
        send_request(OP_ALLOC,   16'd0,     17'd63);
        send_request(OP_ALLOC,   16'd0,     17'd70);
        send_request(OP_RESERVE, 16'hFFFF,  17'h1FFFF);
        send_request(OP_FREE,    16'd0,     17'd1);
        send_request(OP_ALLOC,   16'd0,     17'd1);
        send_request(OP_ALLOC,   16'd0,     17'd65536);
        send_request(OP_ALLOC,   16'd0,     17'h1FFFF);
        send_request(OP_FREE,    16'd0,     17'h1FFFF);
        send_request(OP_ALLOC,   16'd0,     17'd65536);
        send_request(OP_FREE,    16'hFFFF,  17'd1);
        send_request(OP_ALLOC,   16'd0,     17'd1);
        send_request(OP_FREE,    16'd130,   17'd200);
        send_request(OP_ALLOC,   16'd0,     17'd200);

        // A single managed frame, then none at all.
        set_frames_present(17'd1);
        send_request(OP_FREE,    16'd0,     17'd1);
        send_request(OP_ALLOC,   16'd0,     17'd1);
        send_request(OP_ALLOC,   16'd0,     17'd1);
        send_request(OP_RESERVE, 16'd5,     17'd3);
        set_frames_present(17'd0);
        send_request(OP_ALLOC,   16'd0,     17'd1);
        send_request(OP_FREE,    16'd0,     17'd65536);

        // Random traffic over several frame totals.
        for (int p = 0; p < N_PHASES; p++) begin
            lim = (PHASE_TOTAL[p] < 0) ? $urandom_range(2, 2048) : PHASE_TOTAL[p];
            set_frames_present(TOT_W'(lim));
            if (lim > DEF_MAX_FRAMES)
                lim = DEF_MAX_FRAMES;
            quiet_sender   = (p % 3 == 1);
            quiet_receiver = (p % 4 == 2);
            for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
                draw_request(lim, op, first, count);
                send_request(op, first, count);
            end
        end

        // Drain the grants still due, then give the block time to settle.
        req_ch.valid = 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("bitmap_frame_allocator_test OK");
        else
            $display("bitmap_frame_allocator_test NOT OK");
        $finish;
    end

endmodule

### sim.f
rtl/core/bfa_pkg.sv
rtl/core/bfa_in_if.sv
rtl/core/bfa_out_if.sv
rtl/core/bfa_bitmap_mem.sv
rtl/core/bfa_word_unit.sv
rtl/core/bitmap_frame_allocator.sv
rtl/core/bfa_checker.sv
sim/bfa_grant_checker.sv
sim/bitmap_frame_allocator_test.sv
